// ===== design/psa_pkg.sv =====
// ----------------------------------------------------------------------------
// psa_pkg: shared types and constants of the page span allocator
// Pool geometry, operation and status codes, sequencer states and the
// request and result bundles passed between the top level and the engine.
// ----------------------------------------------------------------------------
`default_nettype none
package psa_pkg;

	// pool geometry
	localparam int CHUNK_PAGES      = 128;
	localparam int POOL_CHUNKS      = 8;
	localparam int POOL_PAGES       = CHUNK_PAGES * POOL_CHUNKS;
	localparam int SIZE_CLASSES     = CHUNK_PAGES + 1;
	localparam int PAGE_OFFSET_BITS = 12;
	localparam int CHUNK_SHIFT      = $clog2(CHUNK_PAGES);
	localparam int PAGE_AW          = $clog2(POOL_PAGES);
	localparam int CLS_W            = $clog2(SIZE_CLASSES);
	localparam int CLAIM_W          = 4;
	localparam int LINK_W           = PAGE_AW + 1;

	// free list link with no entry: top bit set
	localparam logic [LINK_W-1:0] LINK_NONE = {1'b1, {PAGE_AW{1'b0}}};

	// operation codes
	localparam logic [1:0] OP_ALLOC   = 2'd0;
	localparam logic [1:0] OP_RELEASE = 2'd1;
	localparam logic [1:0] OP_LOOKUP  = 2'd2;
	localparam logic [1:0] OP_UNUSED  = 2'd3;

	// status codes
	localparam logic [1:0] STS_OK      = 2'd0;
	localparam logic [1:0] STS_OOM     = 2'd1;
	localparam logic [1:0] STS_UNKNOWN = 2'd2;
	localparam logic [1:0] STS_BAD     = 2'd3;

	typedef enum logic [4:0] {
		ST_IDLE,
		ST_A_SCAN, ST_A_HEAD, ST_A_HLEN, ST_A_SPLIT, ST_A_SPUSH, ST_A_FIN,
		ST_A_CLAIM, ST_A_CPUSH,
		ST_R0, ST_R1, ST_B0, ST_B1, ST_B2, ST_B3, ST_B4,
		ST_F0, ST_F1, ST_F2, ST_F3, ST_PSH, ST_R_FIN,
		ST_L0, ST_L1, ST_L2,
		ST_RM0, ST_RM1, ST_PU0, ST_PU1, ST_PU2, ST_MAP,
		ST_DONE
	} state_t;

	typedef struct packed {
		logic [1:0]         operation;
		logic [7:0]         page_count;
		logic [PAGE_AW-1:0] span_page;
		logic [21:0]        byte_address;
	} psa_req_t;

	typedef struct packed {
		logic [PAGE_AW-1:0] span_start;
		logic [7:0]         span_pages;
		logic [1:0]         status;
	} psa_res_t;

	// a page is mapped once the chunk holding it has been claimed
	function automatic logic page_mapped(logic [PAGE_AW-1:0] pg, logic [CLAIM_W-1:0] claimed);
		return {1'b0, pg[PAGE_AW-1:CHUNK_SHIFT]} < claimed;
	endfunction

endpackage
`default_nettype wire

// ===== design/page_span_allocator_top.sv =====
// ----------------------------------------------------------------------------
// page_span_allocator_top: page span allocator
// Span allocator over a pool of eight 128-page chunks with coalescing release.
// ----------------------------------------------------------------------------
// One transaction at a time; in_ready is high only while the sequencer is
// idle, and it returns to idle between transactions. A lookup reads the
// owner table and then the length table of the page's span. An allocate
// scans the size classes upward from the request and unlinks the first span
// it finds; a split writes the remainder, remaps its pages and pushes it back.
// When no list at or above the request holds a span, the allocate claims one
// chunk, remapping every page of it, and scans again. A release merges with
// the spans below and above while the sum fits in a chunk, remapping the
// pages of the upper span to the start of the merged one; a rejected release
// goes straight to the result. The result sits in an output register, so the
// next request is taken while it waits; a second finished result is held in
// the sequencer until the first is taken. No clearing pass is needed after
// reset.
`default_nettype none
module page_span_allocator_top (
	input  wire logic        clk,
	input  wire logic        arst_n,
	input  wire logic        in_valid,
	output logic             in_ready,
	input  wire logic [1:0]  operation,
	input  wire logic [7:0]  page_count,
	input  wire logic [9:0]  span_page,
	input  wire logic [21:0] byte_address,
	output logic             out_valid,
	input  wire logic        out_ready,
	output logic [9:0]       span_start,
	output logic [7:0]       span_pages,
	output logic [1:0]       status,
	input  wire logic        cfg_we,
	input  wire logic [3:0]  cfg_wdata
);

	logic              idle, done, out_free;
	logic [3:0]        chunks_enabled_q;
	logic              out_valid_q;
	psa_pkg::psa_req_t req;
	psa_pkg::psa_res_t res, res_q;

	assign req.operation    = operation;
	assign req.page_count   = page_count;
	assign req.span_page    = span_page;
	assign req.byte_address = byte_address;

	assign out_free = !out_valid_q || out_ready;
	assign in_ready = idle;

	psa_engine u_engine (
		.clk(clk), .arst_n(arst_n), .start(in_valid && idle), .req(req),
		.chunks_enabled(chunks_enabled_q), .out_free(out_free),
		.idle(idle), .done(done), .res(res));

	// configuration register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			chunks_enabled_q <= 4'd8;
		end else if (cfg_we) begin
			chunks_enabled_q <= cfg_wdata;
		end
	end

	// output register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (done) begin
			out_valid_q <= 1'b1;
		end else if (out_ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (done) begin
			res_q <= res;
		end
	end

	assign out_valid  = out_valid_q;
	assign span_start = res_q.span_start;
	assign span_pages = res_q.span_pages;
	assign status     = res_q.status;

endmodule
`default_nettype wire

// ===== design/psa_ram.sv =====
// ----------------------------------------------------------------------------
// psa_ram: simple dual port RAM
// One write port and one read port, read data registered.
// ----------------------------------------------------------------------------
`default_nettype none
module psa_ram #(
	parameter int DEPTH = 1024,
	parameter int WIDTH = 8,
	parameter int AW    = $clog2(DEPTH)
) (
	input  wire logic             clk,
	input  wire logic             we,
	input  wire logic [AW-1:0]    waddr,
	input  wire logic [WIDTH-1:0] wdata,
	input  wire logic [AW-1:0]    raddr,
	output logic      [WIDTH-1:0] rdata
);

	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		rdata <= mem[raddr];
	end

endmodule
`default_nettype wire

// ===== design/psa_engine.sv =====
// ----------------------------------------------------------------------------
// psa_engine: span allocator sequencer
// Walks size classes, unlinks and links free spans and remaps pages under
// a single state machine.
// ----------------------------------------------------------------------------
`default_nettype none
module psa_engine (
	input  wire logic                      clk,
	input  wire logic                      arst_n,
	input  wire logic                      start,
	input  wire psa_pkg::psa_req_t         req,
	input  wire logic [3:0]                chunks_enabled,
	input  wire logic                      out_free,
	output logic                           idle,
	output logic                           done,
	output psa_pkg::psa_res_t              res
);

	localparam int AW = psa_pkg::PAGE_AW;
	localparam int CW = psa_pkg::CLS_W;
	localparam int LW = psa_pkg::LINK_W;
	localparam int CLAIM_W = psa_pkg::CLAIM_W;
	localparam logic [7:0] CHUNK8 = 8'(psa_pkg::CHUNK_PAGES);
	localparam logic [CW-1:0] TOP_CLS = CW'(psa_pkg::CHUNK_PAGES);

	psa_pkg::state_t state_q, state_d, ret_q;

	logic [1:0]         op_q;
	logic [7:0]         n_q;
	logic [AW-1:0]      p_q, pg_q;
	logic [CW-1:0]      cls_q;
	logic               attempt_q;
	logic [psa_pkg::CLAIM_W-1:0] claimed_q;
	logic [AW-1:0]      s_q, cur_q, q_q;
	logic [7:0]         len_q, ql_q;
	logic [AW-1:0]      a_s_q, a_st_q, a_own_q;
	logic [CW-1:0]      a_cls_q;
	logic [7:0]         a_cnt_q, idx_q;
	logic [LW-1:0]      hd_q;
	logic [psa_pkg::SIZE_CLASSES-1:0] nonempty_q;
	logic [AW-1:0]      res_start_q;
	logic [7:0]         res_pages_q;
	logic [1:0]         res_status_q;

	// memory ports
	logic          o_we, l_we, u_we, pv_we, nx_we, h_we;
	logic [AW-1:0] o_wa, o_ra, l_wa, l_ra, u_wa, u_ra, pv_wa, pv_ra, nx_wa, nx_ra;
	logic [CW-1:0] h_wa, h_ra;
	logic [AW-1:0] o_wd, o_rd, h_wd, h_rd;
	logic [7:0]    l_wd, l_rd;
	logic          u_wd, u_rd;
	logic [LW-1:0] pv_wd, pv_rd, nx_wd, nx_rd;

	// derived values
	logic [3:0]    limit;
	logic [AW:0]   fwd_e;
	logic [8:0]    sum_b, sum_f, sum_m;
	logic [AW-1:0] claim_pg;
	logic [LW-1:0] push_hd;

	assign limit    = (chunks_enabled > 4'(psa_pkg::POOL_CHUNKS)) ?
			4'(psa_pkg::POOL_CHUNKS) : chunks_enabled;
	assign fwd_e    = {1'b0, cur_q} + {3'b0, len_q};
	assign sum_b    = {1'b0, l_rd} + {1'b0, len_q};
	assign sum_f    = {1'b0, l_rd} + {1'b0, len_q};
	assign sum_m    = {1'b0, len_q} + {1'b0, ql_q};
	assign claim_pg = {claimed_q[psa_pkg::CLAIM_W-2:0], {psa_pkg::CHUNK_SHIFT{1'b0}}};
	assign push_hd  = nonempty_q[a_cls_q] ? {1'b0, h_rd} : psa_pkg::LINK_NONE;

	// span tables
	psa_ram #(.DEPTH(psa_pkg::POOL_PAGES), .WIDTH(AW)) u_owner (
		.clk(clk), .we(o_we), .waddr(o_wa), .wdata(o_wd), .raddr(o_ra), .rdata(o_rd));
	psa_ram #(.DEPTH(psa_pkg::POOL_PAGES), .WIDTH(8)) u_len (
		.clk(clk), .we(l_we), .waddr(l_wa), .wdata(l_wd), .raddr(l_ra), .rdata(l_rd));
	psa_ram #(.DEPTH(psa_pkg::POOL_PAGES), .WIDTH(1)) u_inuse (
		.clk(clk), .we(u_we), .waddr(u_wa), .wdata(u_wd), .raddr(u_ra), .rdata(u_rd));
	psa_ram #(.DEPTH(psa_pkg::POOL_PAGES), .WIDTH(LW)) u_prev (
		.clk(clk), .we(pv_we), .waddr(pv_wa), .wdata(pv_wd), .raddr(pv_ra), .rdata(pv_rd));
	psa_ram #(.DEPTH(psa_pkg::POOL_PAGES), .WIDTH(LW)) u_next (
		.clk(clk), .we(nx_we), .waddr(nx_wa), .wdata(nx_wd), .raddr(nx_ra), .rdata(nx_rd));
	psa_ram #(.DEPTH(psa_pkg::SIZE_CLASSES), .WIDTH(AW)) u_head (
		.clk(clk), .we(h_we), .waddr(h_wa), .wdata(h_wd), .raddr(h_ra), .rdata(h_rd));

	// next state
	always_comb begin
		state_d = state_q;
		case (state_q)
			psa_pkg::ST_IDLE: begin
				if (start) begin
					case (req.operation)
						psa_pkg::OP_ALLOC: begin
							if (req.page_count == 8'd0 || req.page_count > CHUNK8) begin
								state_d = psa_pkg::ST_DONE;
							end else begin
								state_d = psa_pkg::ST_A_SCAN;
							end
						end
						psa_pkg::OP_RELEASE: state_d = psa_pkg::ST_R0;
						psa_pkg::OP_LOOKUP:  state_d = psa_pkg::ST_L0;
						default:             state_d = psa_pkg::ST_DONE;
					endcase
				end
			end
			psa_pkg::ST_A_SCAN: begin
				if (nonempty_q[cls_q]) begin
					state_d = psa_pkg::ST_A_HEAD;
				end else if (cls_q == TOP_CLS) begin
					state_d = psa_pkg::ST_A_CLAIM;
				end
			end
			psa_pkg::ST_A_HEAD:  state_d = psa_pkg::ST_A_HLEN;
			psa_pkg::ST_A_HLEN:  state_d = psa_pkg::ST_RM0;
			psa_pkg::ST_A_SPLIT: state_d = (len_q > n_q) ? psa_pkg::ST_MAP : psa_pkg::ST_A_FIN;
			psa_pkg::ST_A_SPUSH: state_d = psa_pkg::ST_PU0;
			psa_pkg::ST_A_FIN:   state_d = psa_pkg::ST_DONE;
			psa_pkg::ST_A_CLAIM: begin
				if (attempt_q || claimed_q >= limit) begin
					state_d = psa_pkg::ST_DONE;
				end else begin
					state_d = psa_pkg::ST_MAP;
				end
			end
			psa_pkg::ST_A_CPUSH: state_d = psa_pkg::ST_PU0;
			psa_pkg::ST_R0:      state_d = psa_pkg::ST_R1;
			psa_pkg::ST_R1: begin
				if (!psa_pkg::page_mapped(p_q, claimed_q) || o_rd != p_q || !u_rd) begin
					state_d = psa_pkg::ST_DONE;
				end else begin
					state_d = psa_pkg::ST_B0;
				end
			end
			psa_pkg::ST_B0: begin
				if (cur_q == '0 || !psa_pkg::page_mapped(cur_q - 1'b1, claimed_q)) begin
					state_d = psa_pkg::ST_F0;
				end else begin
					state_d = psa_pkg::ST_B1;
				end
			end
			psa_pkg::ST_B1: state_d = psa_pkg::ST_B2;
			psa_pkg::ST_B2: begin
				if (u_rd || sum_b > 9'(psa_pkg::CHUNK_PAGES)) begin
					state_d = psa_pkg::ST_F0;
				end else begin
					state_d = psa_pkg::ST_RM0;
				end
			end
			psa_pkg::ST_B3: state_d = psa_pkg::ST_MAP;
			psa_pkg::ST_B4: state_d = psa_pkg::ST_B0;
			psa_pkg::ST_F0: begin
				if (fwd_e[AW] || !psa_pkg::page_mapped(fwd_e[AW-1:0], claimed_q)) begin
					state_d = psa_pkg::ST_PSH;
				end else begin
					state_d = psa_pkg::ST_F1;
				end
			end
			psa_pkg::ST_F1: begin
				if (o_rd != fwd_e[AW-1:0] || u_rd || sum_f > 9'(psa_pkg::CHUNK_PAGES)) begin
					state_d = psa_pkg::ST_PSH;
				end else begin
					state_d = psa_pkg::ST_RM0;
				end
			end
			psa_pkg::ST_F2:    state_d = psa_pkg::ST_MAP;
			psa_pkg::ST_F3:    state_d = psa_pkg::ST_F0;
			psa_pkg::ST_PSH:   state_d = psa_pkg::ST_PU0;
			psa_pkg::ST_R_FIN: state_d = psa_pkg::ST_DONE;
			psa_pkg::ST_L0:    state_d = psa_pkg::page_mapped(pg_q, claimed_q) ?
					psa_pkg::ST_L1 : psa_pkg::ST_DONE;
			psa_pkg::ST_L1:    state_d = psa_pkg::ST_L2;
			psa_pkg::ST_L2:    state_d = psa_pkg::ST_DONE;
			psa_pkg::ST_RM0:   state_d = psa_pkg::ST_RM1;
			psa_pkg::ST_RM1:   state_d = ret_q;
			psa_pkg::ST_PU0:   state_d = psa_pkg::ST_PU1;
			psa_pkg::ST_PU1:   state_d = psa_pkg::ST_PU2;
			psa_pkg::ST_PU2:   state_d = ret_q;
			psa_pkg::ST_MAP:   state_d = (idx_q == a_cnt_q - 8'd1) ? ret_q : psa_pkg::ST_MAP;
			psa_pkg::ST_DONE:  state_d = out_free ? psa_pkg::ST_IDLE : psa_pkg::ST_DONE;
			default:           state_d = psa_pkg::ST_IDLE;
		endcase
	end

	// memory controls
	always_comb begin
		o_we = 1'b0; o_wa = '0; o_wd = '0; o_ra = '0;
		l_we = 1'b0; l_wa = '0; l_wd = '0; l_ra = '0;
		u_we = 1'b0; u_wa = '0; u_wd = 1'b0; u_ra = '0;
		pv_we = 1'b0; pv_wa = '0; pv_wd = '0; pv_ra = a_s_q;
		nx_we = 1'b0; nx_wa = '0; nx_wd = '0; nx_ra = a_s_q;
		h_we = 1'b0; h_wa = '0; h_wd = '0; h_ra = a_cls_q;
		case (state_q)
			psa_pkg::ST_A_SCAN: h_ra = cls_q;
			psa_pkg::ST_A_HEAD: l_ra = h_rd;
			psa_pkg::ST_A_SPLIT: begin
				l_wa = s_q + AW'(n_q);
				l_wd = len_q - n_q;
				u_wa = s_q + AW'(n_q);
				l_we = len_q > n_q;
				u_we = len_q > n_q;
			end
			psa_pkg::ST_A_FIN: begin
				l_we = 1'b1; l_wa = s_q; l_wd = n_q;
				u_we = 1'b1; u_wa = s_q; u_wd = 1'b1;
			end
			psa_pkg::ST_A_CLAIM: begin
				l_wa = claim_pg; l_wd = CHUNK8;
				u_wa = claim_pg;
				l_we = !(attempt_q || claimed_q >= limit);
				u_we = !(attempt_q || claimed_q >= limit);
			end
			psa_pkg::ST_R0: begin
				o_ra = p_q; l_ra = p_q; u_ra = p_q;
			end
			psa_pkg::ST_R1: begin
				u_wa = p_q;
				u_we = psa_pkg::page_mapped(p_q, claimed_q) && o_rd == p_q && u_rd;
			end
			psa_pkg::ST_B0: o_ra = cur_q - 1'b1;
			psa_pkg::ST_B1: begin
				l_ra = o_rd; u_ra = o_rd;
			end
			psa_pkg::ST_B4: begin
				l_we = 1'b1; l_wa = q_q; l_wd = sum_m[7:0];
			end
			psa_pkg::ST_F0: begin
				o_ra = fwd_e[AW-1:0]; l_ra = fwd_e[AW-1:0]; u_ra = fwd_e[AW-1:0];
			end
			psa_pkg::ST_F3: begin
				l_we = 1'b1; l_wa = cur_q; l_wd = sum_m[7:0];
			end
			psa_pkg::ST_L0: o_ra = pg_q;
			psa_pkg::ST_L1: l_ra = o_rd;
			psa_pkg::ST_RM1: begin
				// unlink: predecessor or head takes the successor
				nx_we = !pv_rd[LW-1]; nx_wa = pv_rd[AW-1:0]; nx_wd = nx_rd;
				h_we  = pv_rd[LW-1];  h_wa  = a_cls_q;       h_wd  = nx_rd[AW-1:0];
				pv_we = !nx_rd[LW-1]; pv_wa = nx_rd[AW-1:0]; pv_wd = pv_rd;
			end
			psa_pkg::ST_PU1: begin
				pv_we = 1'b1; pv_wa = a_s_q; pv_wd = psa_pkg::LINK_NONE;
				nx_we = 1'b1; nx_wa = a_s_q; nx_wd = push_hd;
				h_we  = 1'b1; h_wa  = a_cls_q; h_wd = a_s_q;
			end
			psa_pkg::ST_PU2: begin
				pv_we = !hd_q[LW-1]; pv_wa = hd_q[AW-1:0]; pv_wd = {1'b0, a_s_q};
			end
			psa_pkg::ST_MAP: begin
				o_we = 1'b1; o_wa = a_st_q + AW'(idx_q); o_wd = a_own_q;
			end
			default: ;
		endcase
	end

	// control state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q    <= psa_pkg::ST_IDLE;
			ret_q      <= psa_pkg::ST_IDLE;
			claimed_q  <= '0;
			nonempty_q <= '0;
			attempt_q  <= 1'b0;
			idx_q      <= '0;
		end else begin
			state_q <= state_d;
			case (state_q)
				psa_pkg::ST_IDLE: attempt_q <= 1'b0;
				psa_pkg::ST_A_HLEN: ret_q <= psa_pkg::ST_A_SPLIT;
				psa_pkg::ST_A_SPLIT: ret_q <= psa_pkg::ST_A_SPUSH;
				psa_pkg::ST_A_SPUSH: ret_q <= psa_pkg::ST_A_FIN;
				psa_pkg::ST_A_CLAIM: begin
					if (!(attempt_q || claimed_q >= limit)) begin
						claimed_q <= claimed_q + 1'b1;
						attempt_q <= 1'b1;
						ret_q     <= psa_pkg::ST_A_CPUSH;
					end
				end
				psa_pkg::ST_A_CPUSH: ret_q <= psa_pkg::ST_A_SCAN;
				psa_pkg::ST_B2: ret_q <= psa_pkg::ST_B3;
				psa_pkg::ST_B3: ret_q <= psa_pkg::ST_B4;
				psa_pkg::ST_F1: ret_q <= psa_pkg::ST_F2;
				psa_pkg::ST_F2: ret_q <= psa_pkg::ST_F3;
				psa_pkg::ST_PSH: ret_q <= psa_pkg::ST_R_FIN;
				psa_pkg::ST_RM1: begin
					if (pv_rd[LW-1]) begin
						nonempty_q[a_cls_q] <= !nx_rd[LW-1];
					end
				end
				psa_pkg::ST_PU1: nonempty_q[a_cls_q] <= 1'b1;
				psa_pkg::ST_MAP: idx_q <= (idx_q == a_cnt_q - 8'd1) ? 8'd0 : idx_q + 8'd1;
				default: ;
			endcase
		end
	end

	// working registers
	always_ff @(posedge clk) begin
		case (state_q)
			psa_pkg::ST_IDLE: begin
				op_q  <= req.operation;
				n_q   <= req.page_count;
				cls_q <= req.page_count;
				p_q   <= req.span_page;
				pg_q  <= req.byte_address[psa_pkg::PAGE_OFFSET_BITS +: AW];
				res_start_q <= '0;
				res_pages_q <= '0;
				res_status_q <= (req.operation == psa_pkg::OP_ALLOC) ?
						psa_pkg::STS_BAD : psa_pkg::STS_BAD;
			end
			psa_pkg::ST_A_SCAN: begin
				if (!nonempty_q[cls_q] && cls_q != TOP_CLS) begin
					cls_q <= cls_q + 1'b1;
				end
			end
			psa_pkg::ST_A_HEAD: s_q <= h_rd;
			psa_pkg::ST_A_HLEN: begin
				len_q   <= l_rd;
				a_s_q   <= s_q;
				a_cls_q <= cls_q;
			end
			psa_pkg::ST_A_SPLIT: begin
				a_st_q  <= s_q + AW'(n_q);
				a_own_q <= s_q + AW'(n_q);
				a_s_q   <= s_q + AW'(n_q);
				a_cnt_q <= len_q - n_q;
				a_cls_q <= CW'(len_q - n_q);
			end
			psa_pkg::ST_A_FIN: begin
				res_start_q  <= s_q;
				res_pages_q  <= n_q;
				res_status_q <= psa_pkg::STS_OK;
			end
			psa_pkg::ST_A_CLAIM: begin
				res_status_q <= psa_pkg::STS_OOM;
				a_st_q  <= claim_pg;
				a_own_q <= claim_pg;
				a_s_q   <= claim_pg;
				a_cnt_q <= CHUNK8;
				a_cls_q <= TOP_CLS;
				cls_q   <= TOP_CLS;
			end
			psa_pkg::ST_R1: begin
				cur_q <= p_q;
				len_q <= l_rd;
				if (!psa_pkg::page_mapped(p_q, claimed_q) || o_rd != p_q) begin
					res_status_q <= psa_pkg::STS_UNKNOWN;
				end
			end
			psa_pkg::ST_B1: q_q <= o_rd;
			psa_pkg::ST_B2: begin
				ql_q    <= l_rd;
				a_s_q   <= q_q;
				a_cls_q <= CW'(l_rd);
			end
			psa_pkg::ST_B3: begin
				a_st_q  <= cur_q;
				a_cnt_q <= len_q;
				a_own_q <= q_q;
			end
			psa_pkg::ST_B4: begin
				len_q <= sum_m[7:0];
				cur_q <= q_q;
			end
			psa_pkg::ST_F1: begin
				q_q     <= fwd_e[AW-1:0];
				ql_q    <= l_rd;
				a_s_q   <= fwd_e[AW-1:0];
				a_cls_q <= CW'(l_rd);
			end
			psa_pkg::ST_F2: begin
				a_st_q  <= q_q;
				a_cnt_q <= ql_q;
				a_own_q <= cur_q;
			end
			psa_pkg::ST_F3: len_q <= sum_m[7:0];
			psa_pkg::ST_PSH: begin
				a_s_q   <= cur_q;
				a_cls_q <= CW'(len_q);
			end
			psa_pkg::ST_R_FIN: begin
				res_start_q  <= cur_q;
				res_pages_q  <= len_q;
				res_status_q <= psa_pkg::STS_OK;
			end
			psa_pkg::ST_L0: res_status_q <= psa_pkg::STS_UNKNOWN;
			psa_pkg::ST_L1: s_q <= o_rd;
			psa_pkg::ST_L2: begin
				res_start_q  <= s_q;
				res_pages_q  <= l_rd;
				res_status_q <= psa_pkg::STS_OK;
			end
			psa_pkg::ST_PU1: hd_q <= push_hd;
			default: ;
		endcase
	end

	assign idle = (state_q == psa_pkg::ST_IDLE);
	assign done = (state_q == psa_pkg::ST_DONE) && out_free;
	assign res.span_start = res_start_q;
	assign res.span_pages = res_pages_q;
	assign res.status     = res_status_q;

	// checks
	a_map_count: assert property (@(posedge clk) disable iff (!arst_n)
		state_q == psa_pkg::ST_MAP |-> a_cnt_q != 8'd0 && idx_q < a_cnt_q)
		else $error("page remap count out of range");
	a_claim_cap: assert property (@(posedge clk) disable iff (!arst_n)
		claimed_q <= CLAIM_W'(psa_pkg::POOL_CHUNKS))
		else $error("more chunks claimed than the pool holds");
	a_ok_pages: assert property (@(posedge clk) disable iff (!arst_n)
		state_q == psa_pkg::ST_DONE && res_status_q == psa_pkg::STS_OK && op_q != psa_pkg::OP_LOOKUP
		|-> res_pages_q != 8'd0 && res_pages_q <= CHUNK8)
		else $error("span length out of range on success");
	a_claim_once: assert property (@(posedge clk) disable iff (!arst_n)
		state_q == psa_pkg::ST_A_CLAIM && attempt_q |=> state_q == psa_pkg::ST_DONE)
		else $error("second chunk claim in one allocation");

endmodule
`default_nettype wire
